// ----- hw/rtl/nfr_pkg.sv -----
// Package for the nibble frame receiver: frame geometry, byte codes and the
// byte type shared by the cell chain and the top level. No dependencies.
package nfr_pkg;

	localparam int FRAME_BYTES = 16;
	// Positions 1 to 14 of a frame are decoded, so the chain keeps the last 14 bytes.
	localparam int CHAIN_CELLS = FRAME_BYTES - 2;
	localparam int POS_W = 5;

	typedef logic [7:0] byte_t;
	typedef logic [POS_W-1:0] pos_t;

	localparam byte_t END_MARK = 8'h3E;
	localparam byte_t NIB_BIAS = 8'h41;

	localparam pos_t POS_LAST = pos_t'(FRAME_BYTES - 1);
	localparam pos_t POS_FULL = pos_t'(FRAME_BYTES);

endpackage

// ----- hw/rtl/nfr_cell.sv -----
// One cell of the receive chain: holds one byte, passes it on to its neighbor on
// every accepted request and presents the byte with the ASCII bias removed.
// Depends on nfr_pkg.
module nfr_cell
	import nfr_pkg::*;
(
	input  logic  clk,
	input  logic  shift_en,
	input  byte_t din,
	output byte_t dout,
	output byte_t dec
);

	byte_t data_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= din;
		end
	end

	assign dout = data_q;
	assign dec  = data_q - NIB_BIAS;

endmodule

// ----- hw/rtl/nibble_frame_receiver.sv -----
// Nibble frame receiver: takes one received byte per cycle while in_ready is
// high and, on each '>' byte, returns one result with the decoded frame. A
// frame is good only when '>' is its sixteenth byte; bad frames give
// frame_ok = 0 with all fields zero. The receive bytes move through a row of
// 14 byte cells, which never stall the input; the result sits in one output
// register, and in_ready falls only while that register holds a result that
// out_ready has not yet taken. A result appears on the cycle after its '>'
// byte is accepted. Depends on nfr_pkg and nfr_cell.
module nibble_frame_receiver
	import nfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_ok,
	output logic [15:0] motor_a,
	output logic [15:0] motor_b,
	output logic [15:0] motor_c,
	output logic [7:0]  info_field,
	output logic [7:0]  extra_field
);

	logic  in_fire;
	logic  is_mark;
	logic  good;
	pos_t  pos_q;
	byte_t link [CHAIN_CELLS+1];
	byte_t dec  [CHAIN_CELLS];

	logic        out_valid_q;
	logic        ok_q;
	logic [15:0] motor_a_q, motor_b_q, motor_c_q;
	logic [7:0]  info_q, extra_q;
	logic [15:0] motor_a_d, motor_b_d, motor_c_d;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign is_mark  = (rx_byte == END_MARK);
	// The marker itself sits at position 15 of a good frame.
	assign good     = is_mark && (pos_q == POS_LAST);

	// Cell 0 holds the newest byte; at a good marker cell k holds frame position 14 - k.
	assign link[0] = rx_byte;
	for (genvar i = 0; i < CHAIN_CELLS; i++) begin : g_cell
		nfr_cell u_cell (
			.clk     (clk),
			.shift_en(in_fire),
			.din     (link[i]),
			.dout    (link[i+1]),
			.dec     (dec[i])
		);
	end

	always_comb begin
		motor_a_d = '0;
		motor_b_d = '0;
		motor_c_d = '0;
		for (int k = 0; k < 4; k++) begin
			motor_a_d[4*k +: 4] = dec[CHAIN_CELLS - 1 - k][3:0];
			motor_b_d[4*k +: 4] = dec[CHAIN_CELLS - 5 - k][3:0];
			motor_c_d[4*k +: 4] = dec[CHAIN_CELLS - 9 - k][3:0];
		end
	end

	// Byte position saturates at two past the last frame position (FRAME_BYTES + 1) to flag an overlong frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_fire) begin
			if (is_mark) begin
				pos_q <= '0;
			end else if (pos_q <= POS_FULL) begin
				pos_q <= pos_q + pos_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && is_mark) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_mark) begin
			ok_q      <= good;
			motor_a_q <= good ? motor_a_d : '0;
			motor_b_q <= good ? motor_b_d : '0;
			motor_c_q <= good ? motor_c_d : '0;
			info_q    <= good ? dec[1] : '0;
			extra_q   <= good ? dec[0] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_ok    = ok_q;
	assign motor_a     = motor_a_q;
	assign motor_b     = motor_b_q;
	assign motor_c     = motor_c_q;
	assign info_field  = info_q;
	assign extra_field = extra_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_FULL + pos_t'(1))
		else $error("byte position beyond saturation");

	a_mark_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_mark |=> pos_q == '0 && out_valid)
		else $error("marker did not restart frame and raise a result");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ok |-> motor_a == '0 && motor_b == '0 && motor_c == '0
			&& info_field == '0 && extra_field == '0)
		else $error("bad frame carries nonzero fields");

	a_no_mark_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> !out_valid || $past(in_fire && is_mark))
		else $error("result raised without a marker");

endmodule
